[rtl/project_point_unified_camera_core_assert.svh]
// Assertion macros for the unified camera projection core.
`ifndef PROJECT_POINT_UNIFIED_CAMERA_CORE_ASSERT_SVH
`define PROJECT_POINT_UNIFIED_CAMERA_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PPUC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppuc assertion failed");

// Condition that must hold on every clock edge outside reset.
`define PPUC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ppuc assertion failed");

`endif

[rtl/ppuc_pkg.sv]
// Types, constants and the divider step function for the unified camera projection core.
package ppuc_pkg;

  localparam int PT_W       = 32;
  localparam int XI_W       = 18;
  localparam int GAIN_W     = 20;
  localparam int OUT_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 26;
  localparam int DEN_W      = 52;
  localparam int LATENCY    = 66;

  localparam logic [XI_W-1:0]   XI_RST = 18'd79167;
  localparam logic [GAIN_W-1:0] FX_RST = 20'd145181;
  localparam logic [GAIN_W-1:0] FY_RST = 20'd145038;
  localparam logic [GAIN_W-1:0] CX_RST = 20'd158632;
  localparam logic [GAIN_W-1:0] CY_RST = 20'd130730;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIRROR_XI = 3'd0,
    REG_FOCAL_X   = 3'd1,
    REG_FOCAL_Y   = 3'd2,
    REG_CENTRE_X  = 3'd3,
    REG_CENTRE_Y  = 3'd4
  } cfg_reg_t;

  // Sideband carried alongside the square root
  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [DEN_W-1:0]  gx;
    logic [DEN_W-1:0]  gy;
    logic signed [PT_W-1:0] z;
  } side_t;

  // One divider lane: partial remainder, quotient so far, bits still to shift in
  typedef struct packed {
    logic [DEN_W:0]       rem;
    logic [DIV_STEPS-1:0] quo;
    logic [DIV_STEPS-1:0] feed;
    logic                 cap;
    logic                 neg;
  } div_lane_t;

  // One restoring division step
  function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] d);
    div_lane_t  o;
    logic [DEN_W:0] t;
    o = l;
    t = {l.rem[DEN_W-1:0], l.feed[DIV_STEPS-1]};
    o.feed = {l.feed[DIV_STEPS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.rem = t - {1'b0, d};
      o.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = t;
      o.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/project_point_unified_camera_core.sv]
// Unified spherical camera projection core, fully pipelined.
// done rises for each accepted point once it has passed every pipeline register below.
// Throughput: one point per cycle while busy is low; 32 square-root and 26 divider stages set the depth.
// Reset (rst, synchronous): the configuration registers return to their defaults, the pipeline is flushed,
// busy is high for one cycle after reset and no request is taken then.
// done marks each result for one cycle only; the receiver cannot stall the pipe.
`include "project_point_unified_camera_core_assert.svh"

module project_point_unified_camera_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [ppuc_pkg::PT_W-1:0]     point_x,
  input  logic signed [ppuc_pkg::PT_W-1:0]     point_y,
  input  logic signed [ppuc_pkg::PT_W-1:0]     point_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ppuc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppuc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 done,
  output logic signed [ppuc_pkg::OUT_W-1:0]    pixel_u,
  output logic signed [ppuc_pkg::OUT_W-1:0]    pixel_v,
  output logic                                 valid_res
);
  import ppuc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [XI_W-1:0]   mirror_xi;
  logic [GAIN_W-1:0] focal_x, focal_y, centre_x, centre_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_xi <= XI_RST;
      focal_x   <= FX_RST;
      focal_y   <= FY_RST;
      centre_x  <= CX_RST;
      centre_y  <= CY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIRROR_XI: mirror_xi <= cfg_data[XI_W-1:0];
        REG_FOCAL_X:   focal_x   <= cfg_data[GAIN_W-1:0];
        REG_FOCAL_Y:   focal_y   <= cfg_data[GAIN_W-1:0];
        REG_CENTRE_X:  centre_x  <= cfg_data[GAIN_W-1:0];
        REG_CENTRE_Y:  centre_y  <= cfg_data[GAIN_W-1:0];
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

  // busy covers reset and the cycle after it; the pipe itself never blocks
  always_ff @(posedge clk) begin
    busy <= rst;
  end
  assign cfg_ready = !busy;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: magnitudes ----------------
  logic                   v1, sx1, sy1;
  logic [PT_W-1:0]        ax1, ay1, az1;
  logic signed [PT_W-1:0] z1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    sx1 <= point_x[PT_W-1];
    sy1 <= point_y[PT_W-1];
    ax1 <= point_x[PT_W-1] ? (~point_x + 1'b1) : point_x;
    ay1 <= point_y[PT_W-1] ? (~point_y + 1'b1) : point_y;
    az1 <= point_z[PT_W-1] ? (~point_z + 1'b1) : point_z;
    z1  <= point_z;
  end

  // ---------------- stage 2: squares and gain products ----------------
  logic                   v2, sx2, sy2;
  logic [2*PT_W-1:0]      qx2, qy2, qz2;
  logic [DEN_W-1:0]       gx2, gy2;
  logic signed [PT_W-1:0] z2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    sx2 <= sx1;
    sy2 <= sy1;
    qx2 <= ax1 * ax1;
    qy2 <= ay1 * ay1;
    qz2 <= az1 * az1;
    gx2 <= ax1 * focal_x;
    gy2 <= ay1 * focal_y;
    z2  <= z1;
  end

  // ---------------- stage 3 and square root stages ----------------
  // Index 0 holds the sum of squares; each later index is one result bit.
  logic              sq_v   [0:SQRT_STEPS];
  logic [2*PT_W-1:0] sq_rem [0:SQRT_STEPS];
  logic [2*PT_W-1:0] sq_res [0:SQRT_STEPS];
  side_t             sq_side[0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v2;
    sq_rem[0]  <= qx2 + qy2 + qz2;  // at most 3 * 2^62, fits
    sq_res[0]  <= '0;
    sq_side[0] <= '{sx: sx2, sy: sy2, gx: gx2, gy: gy2, z: z2};
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [2*PT_W-1:0] BIT = 64'd1 << (2*PT_W - 2 - 2*k);
    logic [2*PT_W:0] trial;
    assign trial = {1'b0, sq_res[k]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else     sq_v[k+1] <= sq_v[k];
      sq_side[k+1] <= sq_side[k];
      if ({1'b0, sq_rem[k]} >= trial) begin
        sq_rem[k+1] <= sq_rem[k] - trial[2*PT_W-1:0];
        sq_res[k+1] <= (sq_res[k] >> 1) + BIT;
      end else begin
        sq_rem[k+1] <= sq_rem[k];
        sq_res[k+1] <= sq_res[k] >> 1;
      end
    end
  end

  // ---------------- xi * r ----------------
  logic                 v36;
  logic [XI_W+PT_W-1:0] p36;
  side_t                side36;

  always_ff @(posedge clk) begin
    if (rst) v36 <= 1'b0;
    else     v36 <= sq_v[SQRT_STEPS];
    p36    <= mirror_xi * sq_res[SQRT_STEPS][PT_W-1:0];
    side36 <= sq_side[SQRT_STEPS];
  end

  // ---------------- denominator d = z * 2^16 + xi * r ----------------
  logic              v37, dpos37;
  logic [DEN_W-1:0]  d37;
  side_t             side37;
  logic signed [DEN_W:0] d_sum;

  assign d_sum = $signed({{5{side36.z[PT_W-1]}}, side36.z, 16'b0})
               + $signed({3'b0, p36});

  always_ff @(posedge clk) begin
    if (rst) v37 <= 1'b0;
    else     v37 <= v36;
    dpos37 <= !d_sum[DEN_W] && (d_sum != '0);
    d37    <= d_sum[DEN_W-1:0];
    side37 <= side36;
  end

  // ---------------- divider set-up: cap test, first partial remainder ----------------
  // A quotient of 1024 or more is clamped; otherwise a >> 10 is already below d,
  // so 26 steps give the whole quotient, which the rounding stage then rounds.
  logic             div_v   [0:DIV_STEPS];
  logic             div_pos [0:DIV_STEPS];
  logic [DEN_W-1:0] div_d   [0:DIV_STEPS];
  div_lane_t        div_x   [0:DIV_STEPS];
  div_lane_t        div_y   [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) div_v[0] <= 1'b0;
    else     div_v[0] <= v37;
    div_pos[0] <= dpos37;
    div_d[0]   <= d37;
    div_x[0] <= '{rem: {11'b0, side37.gx[DEN_W-1:10]}, quo: '0,
                  feed: {side37.gx[9:0], 16'b0},
                  cap: ({10'b0, side37.gx} >= {d37, 10'b0}), neg: side37.sx};
    div_y[0] <= '{rem: {11'b0, side37.gy[DEN_W-1:10]}, quo: '0,
                  feed: {side37.gy[9:0], 16'b0},
                  cap: ({10'b0, side37.gy} >= {d37, 10'b0}), neg: side37.sy};
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) div_v[j+1] <= 1'b0;
      else     div_v[j+1] <= div_v[j];
      div_pos[j+1] <= div_pos[j];
      div_d[j+1]   <= div_d[j];
      div_x[j+1]   <= div_step(div_x[j], div_d[j]);
      div_y[j+1]   <= div_step(div_y[j], div_d[j]);
    end
  end

  // ---------------- rounding, sign and centre ----------------
  // Round half away from zero on the magnitude, then apply the sign.
  localparam logic [DIV_STEPS:0] QUOT_CAP = 27'd1 << DIV_STEPS;

  logic [DIV_STEPS:0]    qmag_x, qmag_y;
  logic                  rup_x, rup_y;
  logic                  v_rd, pos_rd;
  logic signed [28:0]    val_x, val_y;

  always_comb begin
    rup_x  = {div_x[DIV_STEPS].rem, 1'b0} >= {2'b0, div_d[DIV_STEPS]};
    rup_y  = {div_y[DIV_STEPS].rem, 1'b0} >= {2'b0, div_d[DIV_STEPS]};
    qmag_x = div_x[DIV_STEPS].cap ? QUOT_CAP
           : ({1'b0, div_x[DIV_STEPS].quo} + {{DIV_STEPS{1'b0}}, rup_x});
    qmag_y = div_y[DIV_STEPS].cap ? QUOT_CAP
           : ({1'b0, div_y[DIV_STEPS].quo} + {{DIV_STEPS{1'b0}}, rup_y});
  end

  always_ff @(posedge clk) begin
    if (rst) v_rd <= 1'b0;
    else     v_rd <= div_v[DIV_STEPS];
    pos_rd <= div_pos[DIV_STEPS];
    val_x  <= (div_x[DIV_STEPS].neg ? -$signed({2'b0, qmag_x}) : $signed({2'b0, qmag_x}))
            + $signed({9'b0, centre_x});
    val_y  <= (div_y[DIV_STEPS].neg ? -$signed({2'b0, qmag_y}) : $signed({2'b0, qmag_y}))
            + $signed({9'b0, centre_y});
  end

  // ---------------- saturation and output register ----------------
  logic hi_x, lo_x, hi_y, lo_y;
  assign hi_x = val_x > 29'(OUT_MAX);
  assign lo_x = val_x < 29'(OUT_MIN);
  assign hi_y = val_y > 29'(OUT_MAX);
  assign lo_y = val_y < 29'(OUT_MIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      valid_res <= 1'b0;
    end else begin
      done      <= v_rd;
      valid_res <= v_rd && pos_rd && !(hi_x || lo_x || hi_y || lo_y);
    end
    if (!pos_rd) begin
      pixel_u <= '0;
      pixel_v <= '0;
    end else begin
      pixel_u <= hi_x ? OUT_MAX : (lo_x ? OUT_MIN : val_x[OUT_W-1:0]);
      pixel_v <= hi_y ? OUT_MAX : (lo_y ? OUT_MIN : val_y[OUT_W-1:0]);
    end
  end

  // ---------------- assertions ----------------
  `PPUC_ASSERT_IMP(a_done_latency, done, $past(accept, LATENCY))
  `PPUC_ASSERT_IMP(a_valid_needs_done, valid_res, done)
  `PPUC_ASSERT_IMP(a_div_rem_bound, div_v[DIV_STEPS] && div_pos[DIV_STEPS] && !div_x[DIV_STEPS].cap, div_x[DIV_STEPS].rem < {1'b0, div_d[DIV_STEPS]})

endmodule

[tb/tb_project_point_unified_camera_core.sv]
// Self-checking testbench for the unified camera projection core.
`timescale 1ns / 100ps

module tb_project_point_unified_camera_core;
  import ppuc_pkg::*;

  localparam int  CLK_HALF   = 4;
  localparam int  DRAIN_CYC  = 2 * LATENCY + 20;
  localparam int  CYCLE_CAP  = 400000;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] u;
    logic signed [OUT_W-1:0] v;
    logic                    ok;
  } pixel_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [PT_W-1:0] point_x, point_y, point_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic done;
  logic signed [OUT_W-1:0] pixel_u, pixel_v;
  logic valid_res;

  project_point_unified_camera_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .pixel_u(pixel_u), .pixel_v(pixel_v), .valid_res(valid_res)
  );

  // Predictor copy of the camera registers
  logic [XI_W-1:0]   cam_xi;
  logic [GAIN_W-1:0] cam_fx, cam_fy, cam_cx, cam_cy;

  point_t pending_points[$];
  pixel_t expected_pixels[$];
  int     fail_count;
  int     cycle_count;
  bit     idle_gaps;   // sender idling switch; off for the long back-to-back stretch

  // busy as seen at the last rising edge, so acceptance is decided on edge values
  logic busy_seen;

  // Integer square root, floor
  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // round(num * 2^16 / den), ties away from zero, capped at 2^26
  function automatic logic [63:0] rounded_quotient(input logic [63:0] num,
                                                   input logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (q >= 1024) return 64'd67108864;
    for (int i = 0; i < 16; i++) begin
      r <<= 1;
      q <<= 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    if (r >= den - r) q += 1;
    return q;
  endfunction

  // One image axis: scaled projection plus centre, then clamp to Q15.8
  function automatic logic signed [OUT_W-1:0] axis_pixel(
      input logic signed [PT_W-1:0] p, input logic [GAIN_W-1:0] gain,
      input logic [GAIN_W-1:0] centre, input logic [63:0] den, inout logic ok);
    logic [63:0]        mag, q;
    longint signed      val;
    mag = p < 0 ? 64'(-longint'(p)) : 64'(p);
    q   = rounded_quotient(mag * gain, den);
    val = (p < 0 ? -longint'(q) : longint'(q)) + longint'(centre);
    if (val > longint'(OUT_MAX)) begin
      ok = 1'b0;
      return OUT_MAX;
    end
    if (val < longint'(OUT_MIN)) begin
      ok = 1'b0;
      return OUT_MIN;
    end
    return val[OUT_W-1:0];
  endfunction

  function automatic pixel_t project_point(input point_t pt);
    pixel_t        px;
    logic [63:0]   ax, ay, az, sum_sq, radius;
    longint signed den;
    logic          ok;
    ax = pt.x < 0 ? 64'(-longint'(pt.x)) : 64'(pt.x);
    ay = pt.y < 0 ? 64'(-longint'(pt.y)) : 64'(pt.y);
    az = pt.z < 0 ? 64'(-longint'(pt.z)) : 64'(pt.z);
    sum_sq = ax * ax + ay * ay + az * az;
    radius = floor_sqrt(sum_sq);
    den = longint'(pt.z) * 65536 + longint'(64'(cam_xi) * radius);
    px = '0;
    if (den > 0) begin
      ok   = 1'b1;
      px.u = axis_pixel(pt.x, cam_fx, cam_cx, 64'(den), ok);
      px.v = axis_pixel(pt.y, cam_fy, cam_cy, 64'(den), ok);
      px.ok = ok;
    end
    return px;
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Request driver: presents the head of the queue, drops it on an accepting edge
  always @(negedge clk) begin
    if (rst) begin
      start   <= 1'b0;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
    end else begin
      if (start && !busy_seen) void'(pending_points.pop_front());
      if (pending_points.size() != 0 && (!idle_gaps || $urandom_range(99) >= 33)) begin
        start   <= 1'b1;
        point_x <= pending_points[0].x;
        point_y <= pending_points[0].y;
        point_z <= pending_points[0].z;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) busy_seen <= busy;

  // Predict on acceptance, check on done; both at the rising edge
  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst) begin
      if (start && !busy) begin
        expected_pixels.push_back(project_point(point_t'{point_x, point_y, point_z}));
      end
      if (done) begin
        if (expected_pixels.size() == 0) begin
          $error("result with nothing outstanding");
          fail_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (pixel_u !== exp_px.u) begin
            $error("pixel_u expected %0d got %0d", exp_px.u, pixel_u);
            fail_count++;
          end
          if (pixel_v !== exp_px.v) begin
            $error("pixel_v expected %0d got %0d", exp_px.v, pixel_v);
            fail_count++;
          end
          if (valid_res !== exp_px.ok) begin
            $error("valid_res expected %0b got %0b", exp_px.ok, valid_res);
            fail_count++;
          end
        end
      end
    end
  end

  // Register write while the pipe is empty; predictor copy updated at acceptance
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_MIRROR_XI: cam_xi = val[XI_W-1:0];
      REG_FOCAL_X:   cam_fx = val[GAIN_W-1:0];
      REG_FOCAL_Y:   cam_fy = val[GAIN_W-1:0];
      REG_CENTRE_X:  cam_cx = val[GAIN_W-1:0];
      REG_CENTRE_Y:  cam_cy = val[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [PT_W-1:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;                                      // full range
      1:       return {{15{1'($urandom_range(1))}}, 17'($urandom)};  // near zero
      2:       return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed(20'($urandom)) <<< ($urandom_range(12)));
    endcase
  endfunction

  // Mostly points in front of the camera at modest scale, plus raw noise
  task automatic queue_random(input int n);
    point_t pt;
    for (int i = 0; i < n; i++) begin
      pt.x = rand_coord();
      pt.y = rand_coord();
      if ($urandom_range(3) != 0)
        pt.z = 32'($urandom_range(32'h3FFFFFFF, 32'h00001000));
      else
        pt.z = rand_coord();
      pending_points.push_back(pt);
    end
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    idle_gaps = 1'b1;
    cfg_valid = 1'b0; cfg_index = REG_MIRROR_XI; cfg_data = '0;
    cam_xi = XI_RST; cam_fx = FX_RST; cam_fy = FY_RST; cam_cx = CX_RST; cam_cy = CY_RST;
    @(negedge rst);
    repeat (2) @(posedge clk);

    // Directed: on axis, behind camera, zero point, extremes, saturation, ties
    pending_points.push_back('{32'sd0, 32'sd0, 32'sd65536});
    pending_points.push_back('{32'sd65536, -32'sd65536, 32'sd65536});
    pending_points.push_back('{32'sd0, 32'sd0, 32'sd0});
    pending_points.push_back('{32'sd0, 32'sd0, -32'sd65536});
    pending_points.push_back('{32'sd65536, 32'sd0, -32'sd6553600});
    pending_points.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_points.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
    pending_points.push_back('{32'h80000000, 32'h7FFFFFFF, 32'sd1});
    pending_points.push_back('{32'h7FFFFFFF, 32'h80000000, 32'sd1});
    pending_points.push_back('{32'sd1, -32'sd1, 32'sd1});
    pending_points.push_back('{32'sd6553600, -32'sd6553600, 32'sd65536});
    pending_points.push_back('{-32'sd65536, 32'sd131072, 32'sd32768});
    pending_points.push_back('{32'sd1, 32'sd1, 32'h7FFFFFFF});
    drain();

    // Extremes of every register: full scale first, then zero
    write_reg(REG_MIRROR_XI, 32'hFFFFFFFF);
    write_reg(REG_FOCAL_X, 32'hFFFFFFFF);
    write_reg(REG_FOCAL_Y, 32'hFFFFFFFF);
    write_reg(REG_CENTRE_X, 32'hFFFFFFFF);
    write_reg(REG_CENTRE_Y, 32'hFFFFFFFF);
    queue_random(120);
    drain();

    write_reg(REG_MIRROR_XI, 32'd0);
    write_reg(REG_FOCAL_X, 32'd0);
    write_reg(REG_FOCAL_Y, 32'd0);
    write_reg(REG_CENTRE_X, 32'd0);
    write_reg(REG_CENTRE_Y, 32'd0);
    queue_random(120);
    drain();

    // Long back-to-back stretch at reset-like settings
    write_reg(REG_MIRROR_XI, 32'd65536);
    write_reg(REG_FOCAL_X, 32'd128000);
    write_reg(REG_FOCAL_Y, 32'd128000);
    write_reg(REG_CENTRE_X, 32'd163840);
    write_reg(REG_CENTRE_Y, 32'd122880);
    idle_gaps = 1'b0;
    queue_random(300);
    drain();
    idle_gaps = 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_MIRROR_XI, $urandom);
      write_reg(REG_FOCAL_X, $urandom);
      write_reg(REG_FOCAL_Y, $urandom);
      write_reg(REG_CENTRE_X, $urandom);
      write_reg(REG_CENTRE_Y, $urandom);
      queue_random(140);
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ppuc_pkg.sv
rtl/project_point_unified_camera_core.sv
tb/tb_project_point_unified_camera_core.sv
